/* rtl/lcg_pkg.sv */
package lcg_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_COUNT  = 3'd1;
    localparam logic [2:0] REG_COLOR0 = 3'd2;

    localparam int LIFE_W     = 16;
    localparam int CH_W       = 8;
    localparam int COLOR_W    = 32;
    localparam int CNT_W      = 3;
    // One quotient bit per divider stage: the fraction runs 0..65536.
    localparam int QUO_W      = LIFE_W + 1;
    localparam int DIV_STAGES = QUO_W;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    // Classified particle waiting between the front and the back.
    typedef struct packed {
        logic              skip;
        logic [CNT_W-1:0]  nm1;
        logic [LIFE_W-1:0] diff;
        logic [LIFE_W-1:0] start;
    } t_q_entry;

    // Queue status seen by both sides.
    typedef struct packed {
        logic nonempty;
        logic full;
    } t_q_status;

    // Payload of one divider stage.
    typedef struct packed {
        logic              skip;
        logic [CNT_W-1:0]  nm1;
        logic [LIFE_W-1:0] start;
        logic [QUO_W-1:0]  rem;
        logic [QUO_W-1:0]  quo;
    } t_div_stage;

endpackage

/* rtl/lcg_front.sv */
module lcg_front #(
    parameter int MAX_COLORS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lcg_pkg::LIFE_W-1:0]    i_remaining_life,
    input  logic [lcg_pkg::LIFE_W-1:0]    i_starting_life,
    input  logic                          i_enable,
    input  logic [lcg_pkg::CNT_W-1:0]     i_color_count,
    input  lcg_pkg::t_q_status            i_q_status,
    output logic                          o_push,
    output lcg_pkg::t_q_entry             o_entry
);

    logic                       r_fv;
    lcg_pkg::t_q_entry          r_entry;
    lcg_pkg::t_q_entry          n_entry;
    logic [lcg_pkg::CNT_W-1:0]  n_eff;
    logic                       accept;

    assign o_in_stall = r_fv && i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_fv && !i_q_status.full;
    assign o_entry    = r_entry;

    // Clamp the color count and flag particles that produce no color.
    always_comb begin
        if (i_color_count > lcg_pkg::CNT_W'(MAX_COLORS)) begin
            n_eff = lcg_pkg::CNT_W'(MAX_COLORS);
        end else begin
            n_eff = i_color_count;
        end
        n_entry.skip  = !i_enable || (n_eff < lcg_pkg::CNT_W'(2)) ||
                        (i_starting_life == '0) || (i_remaining_life > i_starting_life);
        n_entry.nm1   = n_eff - lcg_pkg::CNT_W'(1);
        n_entry.diff  = i_starting_life - i_remaining_life;
        n_entry.start = i_starting_life;
    end

    // Holding register: filled on a transaction, emptied into the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (accept) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
    end

endmodule

/* rtl/lcg_queue.sv */
module lcg_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  lcg_pkg::t_q_entry  i_entry,
    input  logic               i_pop,
    output lcg_pkg::t_q_entry  o_entry,
    output lcg_pkg::t_q_status o_status
);

    lcg_pkg::t_q_entry            r_slot [lcg_pkg::Q_DEPTH];
    logic [lcg_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [lcg_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [lcg_pkg::Q_PTR_W:0]    r_count;

    assign o_status.nonempty = (r_count != '0);
    assign o_status.full     = (r_count == (lcg_pkg::Q_PTR_W + 1)'(lcg_pkg::Q_DEPTH));
    assign o_entry           = r_slot[r_rd_ptr];

    // Pointers and fill count; the front never pushes into a full queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* rtl/lcg_back.sv */
module lcg_back #(
    parameter int MAX_COLORS = 6
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  lcg_pkg::t_q_status                     i_q_status,
    input  lcg_pkg::t_q_entry                      i_entry,
    output logic                                   o_pop,
    input  logic [MAX_COLORS*lcg_pkg::COLOR_W-1:0] i_colors,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [lcg_pkg::CH_W-1:0]               o_red,
    output logic [lcg_pkg::CH_W-1:0]               o_green,
    output logic [lcg_pkg::CH_W-1:0]               o_blue,
    output logic [lcg_pkg::CH_W-1:0]               o_alpha,
    output logic                                   o_color_valid
);

    localparam int IDX_W = $clog2(MAX_COLORS);
    localparam int LAST  = lcg_pkg::DIV_STAGES - 1;
    localparam int OVL_W = lcg_pkg::QUO_W + lcg_pkg::CNT_W;

    // One restoring division step: {quotient bit, new remainder}.
    function automatic logic [lcg_pkg::QUO_W:0] div_step(
        input logic [lcg_pkg::QUO_W-1:0]  rem,
        input logic [lcg_pkg::LIFE_W-1:0] dvs
    );
        logic [lcg_pkg::QUO_W-1:0] ext;
        ext = {1'b0, dvs};
        if (rem >= ext) begin
            div_step = {1'b1, rem - ext};
        end else begin
            div_step = {1'b0, rem};
        end
    endfunction

    // Linear blend of one channel, t in Q0.8.
    function automatic logic [lcg_pkg::CH_W-1:0] blend(
        input logic [lcg_pkg::CH_W-1:0] a,
        input logic [lcg_pkg::CH_W-1:0] b,
        input logic [lcg_pkg::CH_W-1:0] t
    );
        logic [lcg_pkg::CH_W:0]     inv;
        logic [2*lcg_pkg::CH_W:0]   sum;
        inv   = (lcg_pkg::CH_W + 1)'(256) - {1'b0, t};
        sum   = (2*lcg_pkg::CH_W + 1)'(a) * (2*lcg_pkg::CH_W + 1)'(inv) +
                (2*lcg_pkg::CH_W + 1)'(b) * (2*lcg_pkg::CH_W + 1)'(t);
        blend = sum[2*lcg_pkg::CH_W-1:lcg_pkg::CH_W];
    endfunction

    logic                                adv;
    lcg_pkg::t_div_stage                 r_div [lcg_pkg::DIV_STAGES];
    lcg_pkg::t_div_stage                 n_div [lcg_pkg::DIV_STAGES];
    logic [lcg_pkg::DIV_STAGES-1:0]      r_dv;

    logic [OVL_W-1:0]                    ovl;
    logic                                n_sc_skip;
    logic                                r_sc_v;
    logic                                r_sc_skip;
    logic [IDX_W-1:0]                    r_sc_idx;
    logic [lcg_pkg::CH_W-1:0]            r_sc_t;

    logic [lcg_pkg::COLOR_W-1:0]         c1;
    logic [lcg_pkg::COLOR_W-1:0]         c2;
    logic [4*lcg_pkg::CH_W-1:0]          n_rgba;

    logic                                r_ov;
    logic                                r_cv;
    logic [4*lcg_pkg::CH_W-1:0]          r_rgba;

    // The whole pipeline moves unless a finished result is held up.
    assign adv   = !(r_ov && i_out_stall);
    assign o_pop = adv && i_q_status.nonempty;

    // Divider stages: the first settles the top quotient bit, each later one
    // shifts the remainder and settles the next bit down.
    always_comb begin
        logic [lcg_pkg::QUO_W:0] res;
        res                = div_step({1'b0, i_entry.diff}, i_entry.start);
        n_div[0].skip      = i_entry.skip;
        n_div[0].nm1       = i_entry.nm1;
        n_div[0].start     = i_entry.start;
        n_div[0].rem       = res[lcg_pkg::QUO_W-1:0];
        n_div[0].quo       = '0;
        n_div[0].quo[LAST] = res[lcg_pkg::QUO_W];
        for (int k = 1; k < lcg_pkg::DIV_STAGES; k++) begin
            res                  = div_step({r_div[k-1].rem[lcg_pkg::LIFE_W-1:0], 1'b0},
                                            r_div[k-1].start);
            n_div[k]             = r_div[k-1];
            n_div[k].rem         = res[lcg_pkg::QUO_W-1:0];
            n_div[k].quo[LAST-k] = res[lcg_pkg::QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else if (adv) begin
            r_dv <= {r_dv[lcg_pkg::DIV_STAGES-2:0], i_q_status.nonempty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < lcg_pkg::DIV_STAGES; k++) begin
                r_div[k] <= n_div[k];
            end
        end
    end

    // Scale the fraction across the gradient and split index and weight.
    always_comb begin
        ovl       = OVL_W'(r_div[LAST].quo) * OVL_W'(r_div[LAST].nm1);
        n_sc_skip = r_div[LAST].skip ||
                    (ovl[OVL_W-1:lcg_pkg::LIFE_W] >=
                     (OVL_W - lcg_pkg::LIFE_W)'(r_div[LAST].nm1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_v <= 1'b0;
        end else if (adv) begin
            r_sc_v <= r_dv[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sc_skip <= n_sc_skip;
            r_sc_idx  <= ovl[lcg_pkg::LIFE_W +: IDX_W];
            r_sc_t    <= ovl[lcg_pkg::LIFE_W-1:lcg_pkg::CH_W];
        end
    end

    // Pick the neighbouring colors and blend all four channels.
    always_comb begin
        c1 = '0;
        c2 = '0;
        for (int k = 0; k < MAX_COLORS - 1; k++) begin
            if (r_sc_idx == IDX_W'(k)) begin
                c1 = i_colors[k*lcg_pkg::COLOR_W +: lcg_pkg::COLOR_W];
                c2 = i_colors[(k+1)*lcg_pkg::COLOR_W +: lcg_pkg::COLOR_W];
            end
        end
        for (int ch = 0; ch < 4; ch++) begin
            n_rgba[ch*lcg_pkg::CH_W +: lcg_pkg::CH_W] =
                blend(c1[ch*lcg_pkg::CH_W +: lcg_pkg::CH_W],
                      c2[ch*lcg_pkg::CH_W +: lcg_pkg::CH_W], r_sc_t);
        end
        if (r_sc_skip) begin
            n_rgba = '0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_sc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cv   <= !r_sc_skip;
            r_rgba <= n_rgba;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_color_valid = r_cv;
    assign o_red         = r_rgba[3*lcg_pkg::CH_W +: lcg_pkg::CH_W];
    assign o_green       = r_rgba[2*lcg_pkg::CH_W +: lcg_pkg::CH_W];
    assign o_blue        = r_rgba[1*lcg_pkg::CH_W +: lcg_pkg::CH_W];
    assign o_alpha       = r_rgba[0 +: lcg_pkg::CH_W];

endmodule

/* rtl/lifetime_color_gradient.sv */
// Particle color over lifetime. Each input transaction carries a particle's
// remaining and starting life; one output transaction follows with the RGBA
// color blended from the configured gradient, or color_valid low and zero
// channels when the particle is skipped. One transaction is taken per clock
// cycle while the output is not stalled. The path runs through the holding
// register, the queue, 17 divider stages with the first fed straight from the
// queue head, scaling and output. The pipelined restoring divider forms the
// elapsed fraction one quotient bit per stage. A four-entry queue separates
// input classification from the arithmetic, so each side stalls on its own.
// The user must write configuration only while no transaction is in flight;
// the block itself does not enforce it.
module lifetime_color_gradient #(
    parameter int MAX_COLORS = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_index,
    input  logic [lcg_pkg::COLOR_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [lcg_pkg::LIFE_W-1:0] i_remaining_life,
    input  logic [lcg_pkg::LIFE_W-1:0] i_starting_life,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [lcg_pkg::CH_W-1:0]   o_red,
    output logic [lcg_pkg::CH_W-1:0]   o_green,
    output logic [lcg_pkg::CH_W-1:0]   o_blue,
    output logic [lcg_pkg::CH_W-1:0]   o_alpha,
    output logic                       o_color_valid
);

    logic                                    r_enable;
    logic [lcg_pkg::CNT_W-1:0]               r_count;
    logic [MAX_COLORS*lcg_pkg::COLOR_W-1:0]  r_colors;

    lcg_pkg::t_q_status                      q_status;
    lcg_pkg::t_q_entry                       push_entry;
    lcg_pkg::t_q_entry                       head_entry;
    logic                                    push;
    logic                                    pop;

    // Configuration registers; writes to unused color slots are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_count  <= '0;
            r_colors <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == lcg_pkg::REG_ENABLE) begin
                r_enable <= i_cfg_data[0];
            end
            if (i_cfg_index == lcg_pkg::REG_COUNT) begin
                r_count <= i_cfg_data[lcg_pkg::CNT_W-1:0];
            end
            for (int k = 0; k < MAX_COLORS; k++) begin
                if (i_cfg_index == 3'(lcg_pkg::REG_COLOR0 + 3'(k))) begin
                    r_colors[k*lcg_pkg::COLOR_W +: lcg_pkg::COLOR_W] <= i_cfg_data;
                end
            end
        end
    end

    lcg_front #(
        .MAX_COLORS (MAX_COLORS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_remaining_life (i_remaining_life),
        .i_starting_life  (i_starting_life),
        .i_enable         (r_enable),
        .i_color_count    (r_count),
        .i_q_status       (q_status),
        .o_push           (push),
        .o_entry          (push_entry)
    );

    lcg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    lcg_back #(
        .MAX_COLORS (MAX_COLORS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (q_status),
        .i_entry       (head_entry),
        .o_pop         (pop),
        .i_colors      (r_colors),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_color_valid (o_color_valid)
    );

endmodule

/* rtl/lcg_checker.sv */
module lcg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic [7:0] o_alpha,
    input logic       o_color_valid
);

    // A held output transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_red) &&
        $stable(o_green) && $stable(o_blue) && $stable(o_alpha) &&
        $stable(o_color_valid))
        else $error("output transaction changed while stalled");

    // A skipped particle carries zero channels.
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_color_valid |->
        o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0 && o_alpha == 8'd0)
        else $error("skipped particle with nonzero color");

    // Reset empties the pipeline and releases the input.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear the pipeline");

endmodule

bind lifetime_color_gradient lcg_checker u_lcg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_red         (o_red),
    .o_green       (o_green),
    .o_blue        (o_blue),
    .o_alpha       (o_alpha),
    .o_color_valid (o_color_valid)
);
